>>> sv/sp_pkg.sv
// Shared types and the microcode program for the super-prime checker.
// Used by sp_useq and sp_datapath; depends on nothing else.
package sp_pkg;

	localparam int unsigned QW   = 12;	// query value width
	localparam int unsigned PCW  = 10;	// prime position width
	localparam int unsigned SW   = 4;	// microcode step address width

	localparam logic [QW-1:0]  MIN_PRIME = QW'(2);
	localparam logic [PCW-1:0] TALLY_MAX = {PCW{1'b1}};

	typedef logic [SW-1:0] step_t;

	// Program step addresses
	localparam step_t S_IDLE  = SW'(0);
	localparam step_t S_INIT  = SW'(1);
	localparam step_t S_ONE   = SW'(2);
	localparam step_t S_FILL  = SW'(3);
	localparam step_t S_PINIT = SW'(4);
	localparam step_t S_PTEST = SW'(5);
	localparam step_t S_PMARK = SW'(6);
	localparam step_t S_CROSS = SW'(7);
	localparam step_t S_PNEXT = SW'(8);
	localparam step_t S_CINIT = SW'(9);
	localparam step_t S_COUNT = SW'(10);
	localparam step_t S_RDN   = SW'(11);
	localparam step_t S_RDC   = SW'(12);
	localparam step_t S_EMIT  = SW'(13);

	typedef enum logic [2:0] {
		C_NEVER    = 3'd0,
		C_ALWAYS   = 3'd1,
		C_NO_START = 3'd2,
		C_OOR      = 3'd3,
		C_I_LE_N   = 3'd4,
		C_PSQ_GT_N = 3'd5,
		C_RD_ZERO  = 3'd6
	} cond_t;

	typedef enum logic [1:0] {
		M_NONE = 2'd0,
		M_WR0  = 2'd1,
		M_WR1  = 2'd2,
		M_RD   = 2'd3
	} mem_op_t;

	typedef enum logic [1:0] {
		A_I   = 2'd0,
		A_P   = 2'd1,
		A_N   = 2'd2,
		A_CNT = 2'd3
	} addr_sel_t;

	typedef enum logic [2:0] {
		I_HOLD  = 3'd0,
		I_ZERO  = 3'd1,
		I_INC   = 3'd2,
		I_TWO   = 3'd3,
		I_ADD_P = 3'd4,
		I_DBL_P = 3'd5
	} i_op_t;

	typedef enum logic [1:0] {
		P_HOLD = 2'd0,
		P_TWO  = 2'd1,
		P_INC  = 2'd2
	} p_op_t;

	typedef enum logic [1:0] {
		N_HOLD = 2'd0,
		N_CLR  = 2'd1,
		N_ACC  = 2'd2
	} cnt_op_t;

	typedef struct packed {
		cond_t     cond;
		step_t     target;
		mem_op_t   mem;
		addr_sel_t addr;
		i_op_t     iop;
		p_op_t     pop;
		cnt_op_t   cop;
		logic      set_prime;
		logic      emit;
	} ctrl_t;

	typedef struct packed {
		logic oor;
		logic i_le_n;
		logic psq_gt_n;
		logic rd_zero;
	} flags_t;

	localparam ctrl_t CTRL_NOP = '{
		cond:      C_NEVER,
		target:    S_IDLE,
		mem:       M_NONE,
		addr:      A_I,
		iop:       I_HOLD,
		pop:       P_HOLD,
		cop:       N_HOLD,
		set_prime: 1'b0,
		emit:      1'b0
	};

	// Control store: a jump is taken when cond holds, else the step advances by one.
	function automatic ctrl_t ucode(input step_t s);
		ctrl_t w;
		w = CTRL_NOP;
		case (s)
			S_IDLE: begin
				w.cond = C_NO_START; w.target = S_IDLE;
				w.iop = I_ZERO; w.cop = N_CLR;
			end
			S_INIT: begin
				w.cond = C_OOR; w.target = S_EMIT;
				w.mem = M_WR0; w.addr = A_I; w.iop = I_INC;
			end
			S_ONE: begin
				w.mem = M_WR0; w.addr = A_I; w.iop = I_INC;
			end
			S_FILL: begin
				w.cond = C_I_LE_N; w.target = S_FILL;
				w.mem = M_WR1; w.addr = A_I; w.iop = I_INC;
			end
			S_PINIT: begin
				w.pop = P_TWO;
			end
			S_PTEST: begin
				w.cond = C_PSQ_GT_N; w.target = S_CINIT;
				w.mem = M_RD; w.addr = A_P;
			end
			S_PMARK: begin
				w.cond = C_RD_ZERO; w.target = S_PNEXT;
				w.iop = I_DBL_P;
			end
			S_CROSS: begin
				w.cond = C_I_LE_N; w.target = S_CROSS;
				w.mem = M_WR0; w.addr = A_I; w.iop = I_ADD_P;
			end
			S_PNEXT: begin
				w.cond = C_ALWAYS; w.target = S_PTEST;
				w.pop = P_INC;
			end
			S_CINIT: begin
				w.iop = I_TWO;
			end
			S_COUNT: begin
				w.cond = C_I_LE_N; w.target = S_COUNT;
				w.mem = M_RD; w.addr = A_I; w.iop = I_INC; w.cop = N_ACC;
			end
			S_RDN: begin
				w.mem = M_RD; w.addr = A_N;
			end
			S_RDC: begin
				w.mem = M_RD; w.addr = A_CNT; w.set_prime = 1'b1;
			end
			S_EMIT: begin
				w.cond = C_ALWAYS; w.target = S_IDLE; w.emit = 1'b1;
			end
			default: begin
				w.cond = C_ALWAYS; w.target = S_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

>>> sv/sp_useq.sv
// Microcode sequencer: step counter, control store lookup and jump logic.
// Depends on sp_pkg for the program and the control word type.
module sp_useq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  sp_pkg::flags_t flags,
	output sp_pkg::ctrl_t  ctrl,
	output logic           busy
);

	sp_pkg::step_t upc_q;
	logic          take;

	assign ctrl = sp_pkg::ucode(upc_q);
	assign busy = (upc_q != sp_pkg::S_IDLE);

	always_comb begin
		case (ctrl.cond)
			sp_pkg::C_NEVER:    take = 1'b0;
			sp_pkg::C_ALWAYS:   take = 1'b1;
			sp_pkg::C_NO_START: take = !start;
			sp_pkg::C_OOR:      take = flags.oor;
			sp_pkg::C_I_LE_N:   take = flags.i_le_n;
			sp_pkg::C_PSQ_GT_N: take = flags.psq_gt_n;
			sp_pkg::C_RD_ZERO:  take = flags.rd_zero;
			default:            take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= sp_pkg::S_IDLE;
		end else if (take) begin
			upc_q <= ctrl.target;
		end else begin
			upc_q <= upc_q + sp_pkg::SW'(1);
		end
	end

endmodule

>>> sv/sp_datapath.sv
// Datapath: index and prime registers, the one-bit sieve map, prime counter
// and result registers. Driven by the control word from sp_useq; uses sp_pkg.
module sp_datapath #(
	parameter int unsigned SIEVE_SIZE = 4096
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  logic [sp_pkg::QW-1:0]      query_value,
	input  sp_pkg::ctrl_t              ctrl,
	output sp_pkg::flags_t             flags,
	output logic                       done,
	output logic                       is_super_prime,
	output logic                       value_is_prime,
	output logic [sp_pkg::PCW-1:0]     prime_position
);

	localparam int unsigned AW  = $clog2(SIEVE_SIZE);
	// Wide enough for n + p and for SIEVE_SIZE itself
	localparam int unsigned CW  = (AW + 1 > sp_pkg::QW + 1) ? AW + 1 : sp_pkg::QW + 1;
	localparam int unsigned PW  = 2 * CW;

	logic                   sieve_map_q [0:SIEVE_SIZE-1];
	logic [sp_pkg::QW-1:0]  n_q;
	logic                   oor_q;
	logic [CW-1:0]          i_q;
	logic [CW-1:0]          p_q;
	logic [sp_pkg::PCW-1:0] cnt_q;
	logic                   rd_q;
	logic                   rdv_q;
	logic                   prime_q;
	logic                   done_q;
	logic                   super_q;
	logic                   vprime_q;
	logic [sp_pkg::PCW-1:0] pos_q;

	logic [CW-1:0]          addr;
	logic [CW-1:0]          n_ext;
	logic                   in_range;
	logic [PW-1:0]          psq;

	assign n_ext = CW'(n_q);
	assign psq   = PW'(p_q) * PW'(p_q);

	always_comb begin
		case (ctrl.addr)
			sp_pkg::A_I:   addr = i_q;
			sp_pkg::A_P:   addr = p_q;
			sp_pkg::A_N:   addr = n_ext;
			sp_pkg::A_CNT: addr = CW'(cnt_q);
			default:       addr = i_q;
		endcase
	end

	// Writes touch only entries 0..n, and only reads of entries 0..n are counted
	assign in_range = (addr <= n_ext);

	assign flags.oor      = oor_q;
	assign flags.i_le_n   = (i_q <= n_ext);
	assign flags.psq_gt_n = (psq > PW'(n_q));
	assign flags.rd_zero  = !rd_q;

	// Sieve map: one access per cycle
	always_ff @(posedge clk) begin
		if ((ctrl.mem == sp_pkg::M_WR0 || ctrl.mem == sp_pkg::M_WR1) && in_range) begin
			sieve_map_q[addr[AW-1:0]] <= (ctrl.mem == sp_pkg::M_WR1);
		end
		if (ctrl.mem == sp_pkg::M_RD) begin
			rd_q <= sieve_map_q[addr[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			n_q   <= query_value;
			oor_q <= (CW'(query_value) >= CW'(SIEVE_SIZE));
		end
		case (ctrl.iop)
			sp_pkg::I_HOLD:  i_q <= i_q;
			sp_pkg::I_ZERO:  i_q <= '0;
			sp_pkg::I_INC:   i_q <= i_q + CW'(1);
			sp_pkg::I_TWO:   i_q <= CW'(sp_pkg::MIN_PRIME);
			sp_pkg::I_ADD_P: i_q <= i_q + p_q;
			sp_pkg::I_DBL_P: i_q <= p_q + p_q;
			default:         i_q <= i_q;
		endcase
		case (ctrl.pop)
			sp_pkg::P_HOLD: p_q <= p_q;
			sp_pkg::P_TWO:  p_q <= CW'(sp_pkg::MIN_PRIME);
			sp_pkg::P_INC:  p_q <= p_q + CW'(1);
			default:        p_q <= p_q;
		endcase
		if (ctrl.emit) begin
			super_q  <= prime_q && rd_q;
			vprime_q <= prime_q;
			pos_q    <= cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			rdv_q   <= 1'b0;
			prime_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			// A read is counted the cycle after it is issued
			rdv_q  <= (ctrl.mem == sp_pkg::M_RD) && in_range;
			done_q <= ctrl.emit;
			case (ctrl.cop)
				sp_pkg::N_HOLD: cnt_q <= cnt_q;
				sp_pkg::N_CLR:  cnt_q <= '0;
				sp_pkg::N_ACC: begin
					if (rdv_q && rd_q && cnt_q != sp_pkg::TALLY_MAX) begin
						cnt_q <= cnt_q + sp_pkg::PCW'(1);
					end
				end
				default:        cnt_q <= cnt_q;
			endcase
			if (accept) begin
				prime_q <= 1'b0;
			end else if (ctrl.set_prime) begin
				prime_q <= (n_q >= sp_pkg::MIN_PRIME) && rd_q;
			end
		end
	end

	assign done           = done_q;
	assign is_super_prime = super_q;
	assign value_is_prime = vprime_q;
	assign prime_position = pos_q;

endmodule

>>> sv/super_prime_checker.sv
// Top level of the super-prime checker: microcode sequencer plus datapath.
// Depends on sp_pkg, sp_useq and sp_datapath.
//
// Pulse start with query_value while busy is low. The block rebuilds a sieve
// over 0..n in a single-port one-bit map, counts the primes up to n and
// presents is_super_prime, value_is_prime and prime_position for exactly one
// cycle with done high; the receiver cannot stall, so capture the item then.
// The map takes at most one access per step: an item fills the map over 0..n,
// tests each prime candidate and crosses out the multiples of each sieving
// prime, counts the primes in the map and reads back the map entries at n and
// at the count. A query at or beyond SIEVE_SIZE returns all zeros. A new item
// may start in the cycle that done is high.
module super_prime_checker #(
	parameter int unsigned SIEVE_SIZE = 4096
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [sp_pkg::QW-1:0]  query_value,
	output logic                   done,
	output logic                   is_super_prime,
	output logic                   value_is_prime,
	output logic [sp_pkg::PCW-1:0] prime_position
);

	sp_pkg::ctrl_t  ctrl;
	sp_pkg::flags_t flags;
	logic           accept;

	assign accept = start && !busy;

	sp_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.flags  (flags),
		.ctrl   (ctrl),
		.busy   (busy)
	);

	sp_datapath #(
		.SIEVE_SIZE (SIEVE_SIZE)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.query_value    (query_value),
		.ctrl           (ctrl),
		.flags          (flags),
		.done           (done),
		.is_super_prime (is_super_prime),
		.value_is_prime (value_is_prime),
		.prime_position (prime_position)
	);

endmodule

>>> test/super_prime_checker_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for super_prime_checker: drives query values through
// the start/busy handshake and checks each done item against a local sieve.
// Depends on sp_pkg and the super_prime_checker RTL.
module super_prime_checker_tb;

	localparam int unsigned QW            = sp_pkg::QW;
	localparam int unsigned PCW           = sp_pkg::PCW;
	localparam int unsigned MAP_DEPTH     = 4096;
	localparam int unsigned CYCLE_LIMIT   = 8_000_000;
	localparam int unsigned SETTLE_CYCLES = 40;

	typedef struct {
		logic [QW-1:0]  n;
		logic           super_prime;
		logic           prime;
		logic [PCW-1:0] position;
	} sieve_result_t;

	logic           clk;
	logic           arst_n = 1'b0;
	logic           start = 1'b0;
	logic [QW-1:0]  query_value = '0;
	logic           busy;
	logic           done;
	logic           is_super_prime;
	logic           value_is_prime;
	logic [PCW-1:0] prime_position;

	bit             prime_map [MAP_DEPTH];
	logic [PCW-1:0] tally_q = '0;
	sieve_result_t  pending_results [$];
	int unsigned    sender_idle_pct = 0;
	int unsigned    fail_cnt = 0;
	int unsigned    cycle_cnt = 0;

	super_prime_checker #(
		.SIEVE_SIZE(MAP_DEPTH)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.query_value   (query_value),
		.done          (done),
		.is_super_prime(is_super_prime),
		.value_is_prime(value_is_prime),
		.prime_position(prime_position)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Rebuild the map over 0..n, count primes and derive the expected item.
	function automatic sieve_result_t predict_super_prime(input logic [QW-1:0] n);
		sieve_result_t r;
		int unsigned   count;
		r.n = n;
		r.super_prime = 1'b0;
		r.prime = 1'b0;
		r.position = '0;
		count = 0;
		if (n >= MAP_DEPTH)
			return r;
		prime_map[0] = 1'b0;
		if (n >= 1)
			prime_map[1] = 1'b0;
		for (int unsigned i = 2; i <= n; i++)
			prime_map[i] = 1'b1;
		for (int unsigned p = 2; p * p <= n; p++)
			if (prime_map[p])
				for (int unsigned i = 2 * p; i <= n; i += p)
					prime_map[i] = 1'b0;
		for (int unsigned i = 2; i <= n; i++)
			if (prime_map[i])
				count++;
		r.prime = (n >= 2) && prime_map[n];
		// super-prime test uses the unsaturated count
		r.super_prime = r.prime && prime_map[count];
		tally_q = (count > sp_pkg::TALLY_MAX) ? sp_pkg::TALLY_MAX : PCW'(count);
		r.position = tally_q;
		return r;
	endfunction

	function automatic void check_field(input string field, input int unsigned n,
			input int unsigned want, input int unsigned got);
		if (want != got) begin
			fail_cnt++;
			$display("%0t: n=%0d %s expected %0d, actual %0d", $time, n, field, want, got);
		end
	endfunction

	always @(posedge clk) begin
		sieve_result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				fail_cnt++;
				$display("%0t: unexpected item: expected none, actual super=%0d prime=%0d pos=%0d",
					$time, is_super_prime, value_is_prime, prime_position);
			end else begin
				want = pending_results.pop_front();
				check_field("is_super_prime", want.n, want.super_prime, is_super_prime);
				check_field("value_is_prime", want.n, want.prime, value_is_prime);
				check_field("prime_position", want.n, want.position, prime_position);
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("super_prime_checker regression: fail");
			$finish;
		end
	end

	// Hold start until the item is taken, then idle at random.
	task automatic send_query(input logic [QW-1:0] n);
		int unsigned gap;
		gap = 0;
		start <= 1'b1;
		query_value <= n;
		do @(posedge clk); while (busy);
		pending_results.push_back(predict_super_prime(n));
		while (gap < 400 && $urandom_range(99) < sender_idle_pct)
			gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_all_results();
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [QW-1:0] pick_query();
		int unsigned sel;
		sel = $urandom_range(15);
		// keep most sieves short; full-range values are slow
		if (sel == 0)
			return QW'($urandom_range(4095));
		if (sel < 3)
			return QW'($urandom_range(1023));
		return QW'($urandom_range(255));
	endfunction

	// Values below two, first primes, super-primes and plain composites.
	task automatic test_small_values();
		sender_idle_pct = 0;
		send_query(0);
		send_query(1);
		send_query(2);
		send_query(3);
		send_query(4);
		send_query(5);
		send_query(9);
		send_query(11);
		send_query(17);
		send_query(25);
		send_query(31);
		send_query(127);
		wait_all_results();
	endtask

	// Full map, then the smallest query, the largest prime in the map and edges at powers of 2.
	task automatic test_map_extremes();
		sender_idle_pct = 0;
		send_query(4095);
		send_query(0);
		send_query(4093);
		send_query(4094);
		send_query(2048);
		send_query(2047);
		send_query(1024);
		wait_all_results();
	endtask

	task automatic test_random_queries(input int unsigned count, input int unsigned idle_pct);
		sender_idle_pct = idle_pct;
		for (int unsigned i = 0; i < count; i++) begin
			send_query(pick_query());
			if ($urandom_range(24) == 0)
				wait_all_results();
		end
		wait_all_results();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_small_values();
		test_map_extremes();
		test_random_queries(35, 0);
		test_random_queries(35, 85);
		test_random_queries(30, 20);
		if (fail_cnt == 0 && pending_results.size() == 0)
			$display("super_prime_checker regression: pass");
		else
			$display("super_prime_checker regression: fail");
		$finish;
	end

endmodule

>>> sim.f
sv/sp_pkg.sv
sv/sp_useq.sv
sv/sp_datapath.sv
sv/super_prime_checker.sv
test/super_prime_checker_tb.sv
